/* rtl/psfp_pkg.sv */
// shared types and constants of the particle sensor frame parser
package psfp_pkg;

  localparam int unsigned STORED_BYTES = 30;
  localparam int unsigned MAX_WORDS    = 15;

  localparam logic [7:0]  HDR_FIRST  = 8'h42;
  localparam logic [7:0]  HDR_SECOND = 8'h4D;
  localparam logic [15:0] FRAME_LEN  = 16'(2 * 17 + 2);

  localparam logic [5:0] POS_HDR_FIRST  = 6'd0;
  localparam logic [5:0] POS_HDR_SECOND = 6'd1;
  localparam logic [5:0] POS_LEN_HIGH   = 6'd2;
  localparam logic [5:0] POS_LEN_LOW    = 6'd3;
  localparam logic [5:0] POS_DATA_FIRST = 6'd4;
  localparam logic [5:0] POS_SUM_HIGH   = 6'(2 * 17 + 2 + 2);
  localparam logic [5:0] POS_SUM_LOW    = 6'(2 * 17 + 2 + 3);

  function automatic int unsigned word_count(int unsigned stored_bytes);
    return (stored_bytes / 2 > MAX_WORDS) ? MAX_WORDS : stored_bytes / 2;
  endfunction

  function automatic int unsigned addr_width(int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  typedef enum logic [2:0] {
    S_RECV = 3'b001,
    S_READ = 3'b010,
    S_SHOW = 3'b100
  } state_e;

  typedef struct packed {
    logic take;
    logic rd_en;
    logic cnt_clr;
    logic cnt_inc;
  } cmd_t;

  typedef struct packed {
    logic frame_ok;
    logic last;
  } status_t;

endpackage

/* rtl/psfp_ram.sv */
// generic simple dual port ram with registered read
module psfp_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 15,
  localparam int unsigned AddrW = psfp_pkg::addr_width(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/psfp_datapath.sv */
// byte parsing, checksum and word readout datapath
module psfp_datapath #(
  parameter int unsigned StoredBytes = psfp_pkg::STORED_BYTES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        rx_byte_i,
  input  psfp_pkg::cmd_t    cmd_i,
  output psfp_pkg::status_t status_o,
  output logic [3:0]        word_index_o,
  output logic [15:0]       word_value_o
);

  localparam int unsigned NumWords = psfp_pkg::word_count(StoredBytes);
  localparam int unsigned AddrW    = psfp_pkg::addr_width(NumWords);

  logic [5:0]       pos_q, pos_d, pos;
  logic [15:0]      sum_q, sum_d, sum_add;
  logic [7:0]       len_high_q, len_high_d;
  logic [7:0]       sum_high_q, sum_high_d;
  logic [7:0]       hold_q;
  logic             hold_en;
  logic [AddrW-1:0] cnt_q, cnt_d;
  logic [5:0]       idx;
  logic [4:0]       pair;
  logic             we;
  logic             frame_ok;

  assign pos     = (pos_q > psfp_pkg::POS_SUM_LOW) ? psfp_pkg::POS_HDR_FIRST : pos_q;
  assign sum_add = sum_q + {8'd0, rx_byte_i};
  assign idx     = pos - psfp_pkg::POS_DATA_FIRST;
  assign pair    = idx[5:1];

  always_comb begin
    pos_d      = pos_q;
    sum_d      = sum_q;
    len_high_d = len_high_q;
    sum_high_d = sum_high_q;
    hold_en    = 1'b0;
    we         = 1'b0;
    frame_ok   = 1'b0;
    if (cmd_i.take) begin
      pos_d = pos + 6'd1;
      unique case (pos)
        psfp_pkg::POS_HDR_FIRST: begin
          if (rx_byte_i != psfp_pkg::HDR_FIRST) begin
            pos_d = psfp_pkg::POS_HDR_FIRST;
          end else begin
            sum_d = {8'd0, rx_byte_i};
          end
        end
        psfp_pkg::POS_HDR_SECOND: begin
          if (rx_byte_i != psfp_pkg::HDR_SECOND) begin
            pos_d = psfp_pkg::POS_HDR_FIRST;
          end else begin
            sum_d = sum_add;
          end
        end
        psfp_pkg::POS_LEN_HIGH: begin
          sum_d      = sum_add;
          len_high_d = rx_byte_i;
        end
        psfp_pkg::POS_LEN_LOW: begin
          if ({len_high_q, rx_byte_i} != psfp_pkg::FRAME_LEN) begin
            pos_d = psfp_pkg::POS_HDR_FIRST;
          end else begin
            sum_d = sum_add;
          end
        end
        psfp_pkg::POS_SUM_HIGH: begin
          sum_high_d = rx_byte_i;
        end
        psfp_pkg::POS_SUM_LOW: begin
          pos_d    = psfp_pkg::POS_HDR_FIRST;
          frame_ok = ({sum_high_q, rx_byte_i} == sum_q);
        end
        default: begin
          sum_d = sum_add;
          if (pair < 5'(NumWords)) begin
            hold_en = !idx[0];
            we      = idx[0];
          end
        end
      endcase
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      sum_q      <= '0;
      len_high_q <= '0;
      sum_high_q <= '0;
      cnt_q      <= '0;
    end else begin
      pos_q      <= pos_d;
      sum_q      <= sum_d;
      len_high_q <= len_high_d;
      sum_high_q <= sum_high_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold_en) begin
      hold_q <= rx_byte_i;
    end
  end

  psfp_ram #(
    .Width (16),
    .Depth (NumWords)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (pair[AddrW-1:0]),
    .wdata_i ({hold_q, rx_byte_i}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cnt_q),
    .rdata_o (word_value_o)
  );

  assign word_index_o      = 4'(cnt_q);
  assign status_o.frame_ok = frame_ok;
  assign status_o.last     = (cnt_q == AddrW'(NumWords - 1));

endmodule

/* rtl/psfp_ctrl.sv */
// controller state machine for byte intake and word readout
module psfp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_ready_i,
  input  psfp_pkg::status_t status_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output psfp_pkg::cmd_t    cmd_o
);

  psfp_pkg::state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o.take    = 1'b0;
    cmd_o.rd_en   = 1'b0;
    cmd_o.cnt_clr = 1'b0;
    cmd_o.cnt_inc = 1'b0;
    unique case (state_q)
      psfp_pkg::S_RECV: begin
        cmd_o.take    = in_valid_i;
        cmd_o.cnt_clr = 1'b1;
        if (status_i.frame_ok) begin
          state_d = psfp_pkg::S_READ;
        end
      end
      psfp_pkg::S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = psfp_pkg::S_SHOW;
      end
      psfp_pkg::S_SHOW: begin
        if (out_ready_i) begin
          if (status_i.last) begin
            state_d = psfp_pkg::S_RECV;
          end else begin
            cmd_o.cnt_inc = 1'b1;
            state_d       = psfp_pkg::S_READ;
          end
        end
      end
      default: begin
        state_d = psfp_pkg::S_RECV;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psfp_pkg::S_RECV;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == psfp_pkg::S_RECV);
  assign out_valid_o = (state_q == psfp_pkg::S_SHOW);

`ifndef NO_ASSERTIONS
  a_read_then_show: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == psfp_pkg::S_READ |=> state_q == psfp_pkg::S_SHOW)
    else $error("read not followed by show");

  a_next_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == psfp_pkg::S_SHOW && out_ready_i && !status_i.last)
      |=> state_q == psfp_pkg::S_READ)
    else $error("word burst stopped early");

  a_burst_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == psfp_pkg::S_SHOW && out_ready_i && status_i.last)
      |=> state_q == psfp_pkg::S_RECV)
    else $error("word burst did not end");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == psfp_pkg::S_SHOW && !out_ready_i) |=> state_q == psfp_pkg::S_SHOW)
    else $error("stalled word dropped");
`endif

endmodule

/* rtl/particle_sensor_frame_parser.sv */
// top level of the particle sensor frame parser
//
// input channel: one received serial byte per transaction on rx_byte_i with
// in_valid_i / in_ready_o. a frame is 0x42 0x4d, length 36, 34 data bytes and
// a 16-bit checksum (wrapping sum of all earlier bytes), all big-endian.
// output channel: word_index_o, word_value_o, last_word_o with out_valid_o /
// out_ready_i, one transaction per measurement word.
// in_ready_o is high whenever no word burst is in progress, and a byte offered
// then is taken in that cycle, so bytes stream at one per cycle.
// after the last checksum byte of a good frame, the controller passes through
// S_READ (payload ram read), then S_SHOW (output) for each of the 15 words of
// a burst; the next read starts only once out_ready_i has taken the current
// word. during the burst in_ready_o is low. a stalled receiver holds the
// current word and the burst waits. a bad frame emits nothing.
// reset returns the parser to hunting for the first header byte.
module particle_sensor_frame_parser #(
  parameter int unsigned StoredBytes = psfp_pkg::STORED_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  rx_byte_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic [3:0]  word_index_o,
  output logic [15:0] word_value_o,
  output logic        last_word_o,
  output logic        out_valid_o,
  input  logic        out_ready_i
);

  psfp_pkg::cmd_t    cmd;
  psfp_pkg::status_t status;

  psfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  psfp_datapath #(
    .StoredBytes (StoredBytes)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_byte_i    (rx_byte_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .word_index_o (word_index_o),
    .word_value_o (word_value_o)
  );

  assign last_word_o = status.last;

endmodule
